// File: sv/feac_pkg.sv
// ----------------------------------------------------------------------------
// feac_pkg: shared types and constants
// Widths, reset values and the table entry and cell control types.
// ----------------------------------------------------------------------------
package feac_pkg;

  localparam int KEY_W       = 32;
  localparam int CNT_W       = 8;
  localparam int ENTRIES_DEF = 10;

  localparam logic [CNT_W-1:0] LIMIT_RST = 8'd5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [CNT_W-1:0] COUNT_ONE = 8'd1;
  localparam logic [CNT_W-1:0] LIMIT_OFF = 8'd0;

  typedef struct packed {
    logic [KEY_W-1:0] kx;
    logic [KEY_W-1:0] ky;
    logic [KEY_W-1:0] kz;
  } key_t;

  typedef struct packed {
    logic             valid;
    key_t             key;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             shift_en;   // miss: every cell takes its left neighbor
    logic             upd_en;     // hit: matching cell takes upd_count
    logic [CNT_W-1:0] upd_count;
  } cell_ctl_t;

endpackage

// File: sv/feac_in_if.sv
// ----------------------------------------------------------------------------
// feac_in_if: key channel
// Valid/ready channel carrying one three-word key per transaction.
// ----------------------------------------------------------------------------
interface feac_in_if;
  import feac_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_x;
  logic [KEY_W-1:0] key_y;
  logic [KEY_W-1:0] key_z;

  modport source (output valid, output key_x, output key_y, output key_z, input ready);
  modport sink   (input valid, input key_x, input key_y, input key_z, output ready);
endinterface

// File: sv/feac_out_if.sv
// ----------------------------------------------------------------------------
// feac_out_if: result channel
// Valid/ready channel carrying hit flag, attempt count and allowed flag.
// ----------------------------------------------------------------------------
interface feac_out_if;
  import feac_pkg::*;

  logic             valid;
  logic             ready;
  logic             key_hit;
  logic [CNT_W-1:0] attempt_count;
  logic             allowed;

  modport source (output valid, output key_hit, output attempt_count, output allowed,
                  input ready);
  modport sink   (input valid, input key_hit, input attempt_count, input allowed,
                  output ready);
endinterface

// File: sv/feac_cell.sv
// ----------------------------------------------------------------------------
// feac_cell: one table entry
// Holds one key and its count, compares against the probe key and shifts
// its contents to the right neighbor when a new key is inserted.
// ----------------------------------------------------------------------------
module feac_cell
  import feac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  key_t      probe,
  input  entry_t    ent_in,
  output entry_t    ent_out,
  output logic      match
);

  logic             valid_r;
  key_t             key_r;
  logic [CNT_W-1:0] count_r;

  assign match   = valid_r && (key_r == probe);
  assign ent_out = '{valid: valid_r, key: key_r, count: count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift_en) begin
      valid_r <= ent_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      key_r   <= ent_in.key;
      count_r <= ent_in.count;
    end else if (ctl.upd_en && match) begin
      count_r <= ctl.upd_count;
    end
  end

endmodule

// File: sv/fifo_evicting_attempt_counter_core.sv
// ----------------------------------------------------------------------------
// fifo_evicting_attempt_counter_core: per-key attempt counter, FIFO eviction
// Result path: key_r holds the accepted key, then the output registers take the result.
// Throughput: one key per cycle while the output is not stalled; the key is compared against all cells in
//   the cycle after accept while the next key is taken in.
// Reset: table empty, attempt_limit = 5, no result pending.
// ----------------------------------------------------------------------------
module fifo_evicting_attempt_counter_core
  import feac_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  feac_in_if.sink           in_ch,
  feac_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data
);

  logic [CNT_W-1:0] limit_r;
  logic             pend_r;
  key_t             key_r;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_allowed_r;

  logic             fire;
  logic             in_take;
  logic             tbl_on;
  logic             hit;
  logic [CNT_W-1:0] sel_count;
  logic [CNT_W-1:0] inc_count;
  logic [CNT_W-1:0] new_count;
  cell_ctl_t        ctl;
  entry_t           new_ent;
  entry_t           ent_q [ENTRIES];
  logic [ENTRIES-1:0] match;

  assign fire        = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || fire;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign tbl_on      = (limit_r != LIMIT_OFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_take) begin
      pend_r <= 1'b1;
    end else if (fire) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r <= '{kx: in_ch.key_x, ky: in_ch.key_y, kz: in_ch.key_z};
    end
  end

  // count of the matching cell; keys are unique so at most one bit is set
  always_comb begin
    sel_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_count = sel_count | (match[i] ? ent_q[i].count : '0);
    end
  end

  assign hit       = |match;
  assign inc_count = (sel_count == COUNT_MAX) ? sel_count : sel_count + COUNT_ONE;
  assign new_count = hit ? inc_count : COUNT_ONE;

  assign ctl.shift_en  = fire && tbl_on && !hit;
  assign ctl.upd_en    = fire && tbl_on && hit;
  assign ctl.upd_count = inc_count;

  assign new_ent = '{valid: 1'b1, key: key_r, count: COUNT_ONE};

  // new keys enter at cell 0; the oldest falls off the far end
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    feac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .probe   (key_r),
      .ent_in  ((g == 0) ? new_ent : ent_q[(g == 0) ? 0 : g - 1]),
      .ent_out (ent_q[g]),
      .match   (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (tbl_on) begin
        out_hit_r     <= hit;
        out_count_r   <= new_count;
        out_allowed_r <= (new_count <= limit_r);
      end else begin
        out_hit_r     <= 1'b0;
        out_count_r   <= '0;
        out_allowed_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.key_hit       = out_hit_r;
  assign out_ch.attempt_count = out_count_r;
  assign out_ch.allowed       = out_allowed_r;

endmodule

// File: sv/feac_checker.sv
// ----------------------------------------------------------------------------
// feac_checker: port-level checks
// Result consistency and output channel behavior seen at the top level.
// ----------------------------------------------------------------------------
module feac_checker
  import feac_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_hit,
  input logic [CNT_W-1:0] out_count,
  input logic             out_allowed
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_hit)
      && $stable(out_allowed))
    else $error("result changed while stalled");

  // a fresh key always gets count 1, so a refusal needs a hit and count above 1
  a_deny_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_allowed |-> out_hit && (out_count > COUNT_ONE))
    else $error("refused transaction without prior hits");

  // count zero only when the table is bypassed
  a_zero_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count == '0) |-> out_allowed && !out_hit)
    else $error("zero count on table path");

  a_miss_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit && (out_count != '0) |-> out_count == COUNT_ONE)
    else $error("miss with count other than one");

  // an accepted key yields a result through key_r and the output registers when the output was empty
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after accept");

endmodule

bind fifo_evicting_attempt_counter_core feac_checker u_feac_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_hit     (out_ch.key_hit),
  .out_count   (out_ch.attempt_count),
  .out_allowed (out_ch.allowed)
);
